// ===== rtl/bresenham_line_rasterizer_core_assert.svh =====
// Assertion macros shared by the rasterizer modules.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BLR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/blr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

   localparam int COORD_BITS = 6;
   // Step count holds max(dx, dy) + 1.
   localparam int STEP_BITS  = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 2;
   // Doubled error term and intermediate sums.
   localparam int E2_BITS    = ERR_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] mag_type;
   typedef logic signed [ERR_BITS-1:0]   err_type;
   typedef logic signed [E2_BITS-1:0]    e2_type;
   typedef logic        [STEP_BITS-1:0]  step_type;

   typedef struct packed {
      logic load;   // start a new line from the request fields
      logic step;   // current pixel taken, advance the walk
   } blr_cmd_type;

   typedef struct packed {
      logic last;   // current pixel is the final one
   } blr_status_type;

endpackage

`default_nettype wire

// ===== rtl/blr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface blr_req_if
   import blr_pkg::*;
;
   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;

   modport source (output valid, output start_x, output start_y,
                   output end_x, output end_y, input ready);
   modport sink   (input valid, input start_x, input start_y,
                   input end_x, input end_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/blr_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface blr_rsp_if
   import blr_pkg::*;
;
   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   logic      last_pixel;

   modport source (output valid, output pixel_x, output pixel_y,
                   output last_pixel, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y,
                   input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/blr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "bresenham_line_rasterizer_core_assert.svh"

module blr_ctrl
   import blr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire blr_status_type status,
   output blr_cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign cmd.load  = req_valid & req_ready_ff;
   assign cmd.step  = rsp_valid_ff & rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in     = ST_WALK;
               req_ready_in = 1'b0;
               rsp_valid_in = 1'b1;
            end
         end
         ST_WALK: begin
            if (cmd.step && status.last) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `BLR_ASSERT_NEXT(a_load_shows_pixel, clock, reset, cmd.load,
      rsp_valid_ff && !req_ready_ff, "load did not start the walk")
   `BLR_ASSERT_NEXT(a_last_frees_req, clock, reset, cmd.step && status.last,
      req_ready_ff && !rsp_valid_ff, "last pixel did not end the walk")
   `BLR_ASSERT_NEXT(a_walk_continues, clock, reset, cmd.step && !status.last,
      rsp_valid_ff && !req_ready_ff, "walk stopped early")

endmodule

`default_nettype wire

// ===== rtl/blr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "bresenham_line_rasterizer_core_assert.svh"

module blr_datapath
   import blr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire blr_cmd_type cmd,
   input  wire coord_type start_x,
   input  wire coord_type start_y,
   input  wire coord_type end_x,
   input  wire coord_type end_y,
   output coord_type      pixel_x,
   output coord_type      pixel_y,
   output blr_status_type status
);

   localparam int PAD_BITS = E2_BITS - COORD_BITS;

   coord_type walk_x_ff, walk_x_in;
   coord_type walk_y_ff, walk_y_in;
   err_type   error_term_ff, error_term_in;
   step_type  steps_left_ff, steps_left_in;
   mag_type   dx_ff, dx_in;
   mag_type   dy_ff, dy_in;
   logic      sx_neg_ff, sx_neg_in;
   logic      sy_neg_ff, sy_neg_in;
   coord_type end_x_ff, end_x_in;
   coord_type end_y_ff, end_y_in;

   logic signed [COORD_BITS:0] diff_x, diff_y, abs_x, abs_y;
   mag_type major;
   e2_type  e2, dx_ext, dy_ext, err_ext, err_sum;
   logic    move_x, move_y;

   // Setup from the request
   always_comb begin
      diff_x = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      diff_y = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
      abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
      abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
      dx_in  = abs_x[COORD_BITS-1:0];
      dy_in  = abs_y[COORD_BITS-1:0];
      major  = (dx_in > dy_in) ? dx_in : dy_in;
   end

   // Error walk
   always_comb begin
      dx_ext  = $signed({{PAD_BITS{1'b0}}, dx_ff});
      dy_ext  = $signed({{PAD_BITS{1'b0}}, dy_ff});
      err_ext = $signed({error_term_ff[ERR_BITS-1], error_term_ff});
      e2      = $signed({error_term_ff, 1'b0});
      move_x  = (e2 >= -dy_ext);
      move_y  = (e2 <= dx_ext);
      err_sum = err_ext - (move_x ? dy_ext : '0) + (move_y ? dx_ext : '0);
   end

   assign status.last = ((walk_x_ff == end_x_ff) && (walk_y_ff == end_y_ff))
                        || (steps_left_ff == STEP_BITS'(1));
   assign pixel_x = walk_x_ff;
   assign pixel_y = walk_y_ff;

   always_comb begin
      walk_x_in     = walk_x_ff;
      walk_y_in     = walk_y_ff;
      error_term_in = error_term_ff;
      steps_left_in = steps_left_ff;
      sx_neg_in     = sx_neg_ff;
      sy_neg_in     = sy_neg_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      if (cmd.load) begin
         walk_x_in     = start_x;
         walk_y_in     = start_y;
         error_term_in = $signed({2'b00, dx_in}) - $signed({2'b00, dy_in});
         steps_left_in = {1'b0, major} + STEP_BITS'(1);
         sx_neg_in     = !(start_x < end_x);
         sy_neg_in     = !(start_y < end_y);
         end_x_in      = end_x;
         end_y_in      = end_y;
      end else if (cmd.step) begin
         if (status.last) begin
            steps_left_in = '0;
         end else begin
            steps_left_in = steps_left_ff - STEP_BITS'(1);
            error_term_in = err_sum[ERR_BITS-1:0];
            if (move_x) begin
               walk_x_in = sx_neg_ff ? walk_x_ff - COORD_BITS'(1) : walk_x_ff + COORD_BITS'(1);
            end
            if (move_y) begin
               walk_y_in = sy_neg_ff ? walk_y_ff - COORD_BITS'(1) : walk_y_ff + COORD_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_x_ff     <= '0;
         walk_y_ff     <= '0;
         error_term_ff <= '0;
         steps_left_ff <= '0;
      end else begin
         walk_x_ff     <= walk_x_in;
         walk_y_ff     <= walk_y_in;
         error_term_ff <= error_term_in;
         steps_left_ff <= steps_left_in;
      end
   end

   // Line geometry, loaded with each request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      end_x_ff  <= end_x_in;
      end_y_ff  <= end_y_in;
   end

   `BLR_ASSERT_NEXT(a_load_start, clock, reset, cmd.load,
      (walk_x_ff == $past(start_x)) && (walk_y_ff == $past(start_y)),
      "walk did not start at the start point")
   `BLR_ASSERT_NEXT(a_count_down, clock, reset, cmd.step && !status.last,
      steps_left_ff == $past(steps_left_ff) - STEP_BITS'(1), "step count out of order")
   `BLR_ASSERT_NEXT(a_pixel_moves, clock, reset, cmd.step && !status.last,
      (walk_x_ff != $past(walk_x_ff)) || (walk_y_ff != $past(walk_y_ff)), "pixel repeated")

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_rasterizer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bresenham line rasterizer, all eight octants.
// req_chan: one request per line, start_x/start_y/end_x/end_y, signed
//   coordinates. Accepted when valid and ready are both high.
// rsp_chan: one result per pixel, pixel_x/pixel_y, start point first and
//   end point last; last_pixel marks the end point. A line gives
//   max(|dx|, |dy|) + 1 pixels, 1 to 64 for 6-bit coordinates.
// Latency: the first pixel is valid the cycle after the request is taken.
// Throughput: one pixel per cycle while the receiver takes them; req
//   ready rises again the cycle after the last pixel is taken. One line
//   at a time, set by the single error-term walker.
// Stall: with rsp ready low, the current pixel holds on the channel and
//   the walk waits; nothing is dropped.
// Reset (synchronous, active high): walk cleared, no pixel valid, the
//   request side is ready.
module bresenham_line_rasterizer_core
   import blr_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   blr_req_if.sink   req_chan,
   blr_rsp_if.source rsp_chan
);

   blr_cmd_type    cmd;
   blr_status_type status;

   // Sequencer: idle / walking, owns both handshakes.
   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Walker: current pixel, error term and step count live here; the
   // registered pixel drives the result payload directly.
   blr_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .start_x (req_chan.start_x),
      .start_y (req_chan.start_y),
      .end_x   (req_chan.end_x),
      .end_y   (req_chan.end_y),
      .pixel_x (rsp_chan.pixel_x),
      .pixel_y (rsp_chan.pixel_y),
      .status  (status)
   );

   assign rsp_chan.last_pixel = status.last;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import blr_pkg::*;

   localparam int IDLE_LIMIT   = 2000;   // cycles with no request or pixel taken
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_LINES  = 43;
   localparam int SHOW_LIMIT   = 10;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_rec_type;

   // Walks each accepted line and holds the pixels still owed by the block.
   class line_pixel_tracker;
      pixel_rec_type pending_pixels[$];
      int mismatches;
      int lines_seen;
      int pixels_seen;
      int longest_line;

      function void add_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
         int cx, cy, tx, ty, dx, dy, step_x, step_y, err, e2, remaining, count;
         bit done;
         pixel_rec_type rec;
         cx = sx;
         cy = sy;
         tx = ex;
         ty = ey;
         dx = (tx > cx) ? tx - cx : cx - tx;
         dy = (ty > cy) ? ty - cy : cy - ty;
         step_x = (cx < tx) ? 1 : -1;
         step_y = (cy < ty) ? 1 : -1;
         err = dx - dy;
         count = ((dx > dy) ? dx : dy) + 1;
         remaining = count;
         done = 1'b0;
         while (!done) begin
            rec.x    = coord_type'(cx);
            rec.y    = coord_type'(cy);
            rec.last = (cx == tx && cy == ty) || remaining == 1;
            pending_pixels.push_back(rec);
            remaining--;
            done = rec.last;
            if (!done) begin
               // ties move that axis: both compares include equality
               e2 = 2 * err;
               if (e2 >= -dy) begin
                  err -= dy;
                  cx += step_x;
               end
               if (e2 <= dx) begin
                  err += dx;
                  cy += step_y;
               end
            end
         end
         lines_seen++;
         if (count > longest_line) longest_line = count;
      endfunction

      function void check_pixel(coord_type px, coord_type py, logic last);
         pixel_rec_type want;
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("tb: stray pixel (%0d,%0d) last=%b with no line pending",
                        px, py, last);
            return;
         end
         want = pending_pixels.pop_front();
         if (px !== want.x || py !== want.y || last !== want.last) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("tb: pixel mismatch: expected (%0d,%0d) last=%b, got (%0d,%0d) last=%b",
                        want.x, want.y, want.last, px, py, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   idle_cycles;
   line_pixel_tracker tracker;

   blr_req_if req_chan ();
   blr_rsp_if rsp_chan ();

   bresenham_line_rasterizer_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Pixel side back-pressure.
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Sample both handshakes at the rising edge; also the stall watchdog.
   always @(posedge clock) begin : monitor
      bit busy;
      busy = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            tracker.add_line(req_chan.start_x, req_chan.start_y,
                             req_chan.end_x, req_chan.end_y);
            busy = 1'b1;
         end
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            tracker.check_pixel(rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.last_pixel);
            busy = 1'b1;
         end
         if (busy) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("tb: no request or pixel moved for %0d cycles", IDLE_LIMIT);
               $display("tb: FAIL");
               $finish;
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_line(coord_type sx, coord_type sy, coord_type ex, coord_type ey);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid   <= 1'b0;
         req_chan.start_x <= coord_type'($urandom_range(63));
         req_chan.start_y <= coord_type'($urandom_range(63));
         req_chan.end_x   <= coord_type'($urandom_range(63));
         req_chan.end_y   <= coord_type'($urandom_range(63));
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= sx;
      req_chan.start_y <= sy;
      req_chan.end_x   <= ex;
      req_chan.end_y   <= ey;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Mostly arbitrary endpoints, plus short, axis-aligned and diagonal lines.
   task automatic send_random_line();
      int kind, span;
      coord_type ax, ay, bx, by;
      kind = $urandom_range(99);
      ax = coord_type'($urandom_range(63));
      ay = coord_type'($urandom_range(63));
      bx = coord_type'($urandom_range(63));
      by = coord_type'($urandom_range(63));
      if (kind >= 60 && kind < 80) begin
         bx = ax + coord_type'($urandom_range(8)) - coord_type'(4);
         by = ay + coord_type'($urandom_range(8)) - coord_type'(4);
      end else if (kind >= 80 && kind < 90) begin
         if (kind[0]) bx = ax;
         else         by = ay;
      end else if (kind >= 90) begin
         span = $urandom_range(20);
         bx = ax + coord_type'(span);
         by = kind[0] ? ay + coord_type'(span) : ay - coord_type'(span);
      end
      send_line(ax, ay, bx, by);
   endtask

   initial begin
      tracker          = new();
      reset            = 1'b1;
      send_idle_pct    = 25;
      recv_idle_pct    = 84;
      req_chan.valid   = 1'b0;
      req_chan.start_x = '0;
      req_chan.start_y = '0;
      req_chan.end_x   = '0;
      req_chan.end_y   = '0;
      rsp_chan.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single points, incl. window corners
      send_line(0, 0, 0, 0);
      send_line(-32, -32, -32, -32);
      send_line(31, 31, 31, 31);
      // full-width axis lines both ways
      send_line(-32, 0, 31, 0);
      send_line(31, -5, -32, -5);
      send_line(3, -32, 3, 31);
      send_line(-7, 31, -7, -32);
      // full diagonals
      send_line(-32, -32, 31, 31);
      send_line(31, 31, -32, -32);
      send_line(-32, 31, 31, -32);
      // one line per octant
      send_line(0, 0, 20, 7);
      send_line(0, 0, 7, 20);
      send_line(0, 0, -7, 20);
      send_line(0, 0, -20, 7);
      send_line(0, 0, -20, -7);
      send_line(0, 0, -7, -20);
      send_line(0, 0, 7, -20);
      send_line(0, 0, 20, -7);
      // error-term ties
      send_line(0, 0, 4, 2);
      send_line(-1, -1, 1, 0);
      send_line(10, 10, 4, 13);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 25;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (PHASE_LINES) send_random_line();
      end
      req_chan.valid <= 1'b0;

      while (tracker.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d lines drawn, %0d pixels checked, longest line %0d pixels",
               tracker.lines_seen, tracker.pixels_seen, tracker.longest_line);
      $display("tb: points, axis lines, diagonals, all octants; three stall mixes");
      if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: %0d mismatches, %0d pixels missing",
                  tracker.mismatches, tracker.pending_pixels.size());
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
